/* hdl/rgbhsv_pkg.sv */
// Shared types and constants of the RGB to HSV converter.
package rgbhsv_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 15;
    // Sum of sector offset and signed numerator stays below six times delta
    localparam int TOTAL_BITS   = CHANNEL_BITS + 3;
    // One sector is 3840 units of 1/64 degree: x * 3840 = (x << 12) - (x << 8)
    localparam int UNIT_SHIFT_HI = 12;
    localparam int UNIT_SHIFT_LO = 8;
    localparam int HNUM_BITS    = TOTAL_BITS + UNIT_SHIFT_HI;
    localparam int SNUM_BITS    = 2 * CHANNEL_BITS;
    localparam int DIV_STAGES   = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
    // Two front stages, the divider stages and the output register
    localparam int PIPE_LATENCY = DIV_STAGES + 3;
    localparam int HUE_MAX      = 23039;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [CHANNEL_BITS:0]   num_t;
    typedef logic [TOTAL_BITS-1:0]   total_t;
    typedef logic [HNUM_BITS-1:0]    hnum_t;
    typedef logic [SNUM_BITS-1:0]    snum_t;
    typedef logic [HUE_BITS-1:0]     hue_t;

    typedef enum logic [1:0] {
        SECT_RED_POS,
        SECT_RED_NEG,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        chan_t   value;
        chan_t   delta;
        num_t    num;
        sector_t sector;
    } front_t;

    typedef struct packed {
        logic  grey;
        chan_t value;
        chan_t delta;
        hnum_t h_rem;
        snum_t s_rem;
        hue_t  h_quo;
        chan_t s_quo;
    } div_t;

endpackage

/* hdl/rgbhsv_front.sv */
// Front end: channel extremes, hexcone sector and the two division numerators.
module rgbhsv_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  rgbhsv_pkg::chan_t     red,
    input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0] green,
    input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0] blue,
    output logic                  out_valid,
    output rgbhsv_pkg::div_t      out_data
);

    rgbhsv_pkg::front_t s1_next;
    rgbhsv_pkg::front_t s1_reg;
    logic               s1_valid_reg;
    rgbhsv_pkg::div_t   s2_next;
    rgbhsv_pkg::div_t   s2_reg;
    logic               s2_valid_reg;

    rgbhsv_pkg::chan_t  mx;
    rgbhsv_pkg::chan_t  mn;
    rgbhsv_pkg::total_t offset;
    rgbhsv_pkg::total_t total;

    // Stage 1: extremes and sector; ties go to red, then green
    always_comb
    begin
        mx = (red > green) ? red : green;
        mn = (red < green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (mn < blue) ? mn : blue;
        s1_next.value = mx;
        s1_next.delta = mx - mn;
        if (red >= green && red >= blue)
        begin
            s1_next.num    = {1'b0, green} - {1'b0, blue};
            s1_next.sector = s1_next.num[rgbhsv_pkg::CHANNEL_BITS] ?
                             rgbhsv_pkg::SECT_RED_NEG : rgbhsv_pkg::SECT_RED_POS;
        end
        else if (green >= blue)
        begin
            s1_next.num    = {1'b0, blue} - {1'b0, red};
            s1_next.sector = rgbhsv_pkg::SECT_GREEN;
        end
        else
        begin
            s1_next.num    = {1'b0, red} - {1'b0, green};
            s1_next.sector = rgbhsv_pkg::SECT_BLUE;
        end
    end

    // Stage 2: add sector offset, scale to 1/64 degree, build saturation numerator
    always_comb
    begin
        case (s1_reg.sector)
            rgbhsv_pkg::SECT_RED_NEG:
                offset = (rgbhsv_pkg::total_t'(s1_reg.delta) << 2)
                       + (rgbhsv_pkg::total_t'(s1_reg.delta) << 1);
            rgbhsv_pkg::SECT_GREEN:
                offset = rgbhsv_pkg::total_t'(s1_reg.delta) << 1;
            rgbhsv_pkg::SECT_BLUE:
                offset = rgbhsv_pkg::total_t'(s1_reg.delta) << 2;
            default:
                offset = '0;
        endcase
        total = offset + {{(rgbhsv_pkg::TOTAL_BITS - rgbhsv_pkg::CHANNEL_BITS - 1)
                           {s1_reg.num[rgbhsv_pkg::CHANNEL_BITS]}}, s1_reg.num};

        s2_next.grey  = (s1_reg.delta == '0);
        s2_next.value = s1_reg.value;
        s2_next.delta = s1_reg.delta;
        s2_next.h_rem = (rgbhsv_pkg::hnum_t'(total) << rgbhsv_pkg::UNIT_SHIFT_HI)
                      - (rgbhsv_pkg::hnum_t'(total) << rgbhsv_pkg::UNIT_SHIFT_LO);
        s2_next.s_rem = (rgbhsv_pkg::snum_t'(s1_reg.delta) << rgbhsv_pkg::CHANNEL_BITS)
                      - rgbhsv_pkg::snum_t'(s1_reg.delta);
        s2_next.h_quo = '0;
        s2_next.s_quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

endmodule

/* hdl/rgbhsv_divider.sv */
// Pipelined restoring divider: one hue bit per stage, saturation in last CHANNEL_BITS.
module rgbhsv_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rgbhsv_pkg::div_t in_data,
    output logic             out_valid,
    output rgbhsv_pkg::div_t out_data
);

    rgbhsv_pkg::div_t stage_reg  [rgbhsv_pkg::DIV_STAGES];
    logic             valid_reg  [rgbhsv_pkg::DIV_STAGES];
    rgbhsv_pkg::div_t stage_next [rgbhsv_pkg::DIV_STAGES];

    for (genvar k = 0; k < rgbhsv_pkg::DIV_STAGES; k++)
    begin : g_stage
        localparam int Bit = rgbhsv_pkg::DIV_STAGES - 1 - k;

        rgbhsv_pkg::div_t cur;
        logic             cur_valid;
        rgbhsv_pkg::hnum_t h_rem_n;
        rgbhsv_pkg::hue_t  h_quo_n;
        rgbhsv_pkg::snum_t s_rem_n;
        rgbhsv_pkg::chan_t s_quo_n;

        if (k == 0)
        begin : g_first
            assign cur       = in_data;
            assign cur_valid = in_valid;
        end
        else
        begin : g_next
            assign cur       = stage_reg[k-1];
            assign cur_valid = valid_reg[k-1];
        end

        if (Bit < rgbhsv_pkg::HUE_BITS)
        begin : g_hue
            rgbhsv_pkg::hnum_t h_sub;
            logic              h_take;
            assign h_sub   = rgbhsv_pkg::hnum_t'(cur.delta) << Bit;
            assign h_take  = (cur.h_rem >= h_sub);
            assign h_rem_n = h_take ? (cur.h_rem - h_sub) : cur.h_rem;
            assign h_quo_n = h_take ? (cur.h_quo | (rgbhsv_pkg::hue_t'(1) << Bit))
                                    : cur.h_quo;
        end
        else
        begin : g_hue_idle
            assign h_rem_n = cur.h_rem;
            assign h_quo_n = cur.h_quo;
        end

        if (Bit < rgbhsv_pkg::CHANNEL_BITS)
        begin : g_sat
            rgbhsv_pkg::snum_t s_sub;
            logic              s_take;
            assign s_sub   = rgbhsv_pkg::snum_t'(cur.value) << Bit;
            assign s_take  = (cur.s_rem >= s_sub);
            assign s_rem_n = s_take ? (cur.s_rem - s_sub) : cur.s_rem;
            assign s_quo_n = s_take ? (cur.s_quo | (rgbhsv_pkg::chan_t'(1) << Bit))
                                    : cur.s_quo;
        end
        else
        begin : g_sat_idle
            assign s_rem_n = cur.s_rem;
            assign s_quo_n = cur.s_quo;
        end

        always_comb
        begin
            stage_next[k]       = cur;
            stage_next[k].h_rem = h_rem_n;
            stage_next[k].h_quo = h_quo_n;
            stage_next[k].s_rem = s_rem_n;
            stage_next[k].s_quo = s_quo_n;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= cur_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[k] <= stage_next[k];
        end
    end

    assign out_valid = valid_reg[rgbhsv_pkg::DIV_STAGES-1];
    assign out_data  = stage_reg[rgbhsv_pkg::DIV_STAGES-1];

`ifndef NO_ASSERTIONS
    // Final remainders must be below their divisors for any non-grey pixel
    a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.grey |->
            out_data.h_rem < rgbhsv_pkg::hnum_t'(out_data.delta))
        else $error("hue remainder not below delta");

    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.grey |->
            out_data.s_rem < rgbhsv_pkg::snum_t'(out_data.value))
        else $error("saturation remainder not below max");
`endif

endmodule

/* hdl/rgb_to_hsv_converter.sv */
// Top level of the RGB to HSV converter: front end, divider pipeline, result register.
//
// Converts one RGB pixel per clock into hue (1/64 degree, 0..23039), saturation
// (delta * 255 / max, truncated) and value (largest channel). A request is taken
// at every rising edge with start high; busy is always low because the pipeline
// never stalls and the receiver cannot hold results off. Throughput is one pixel
// per clock. Done pulses for one cycle, with the result on hue, saturation and
// value, once the pixel has passed the front stages, the divider stages and
// the output register. Most of these stages belong to the restoring divider, which
// resolves one hue quotient bit per stage (15 stages); saturation is computed in
// the last CHANNEL_BITS of those stages. Results come out in request order. Grey
// pixels (all channels equal) give hue and saturation of zero.
module rgb_to_hsv_converter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]   red,
    input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]   green,
    input  logic [rgbhsv_pkg::CHANNEL_BITS-1:0]   blue,
    output logic                                  done,
    output logic [rgbhsv_pkg::HUE_BITS-1:0]       hue,
    output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]   saturation,
    output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]   value
);

    logic             accept;
    logic             front_valid;
    rgbhsv_pkg::div_t front_data;
    logic             div_valid;
    rgbhsv_pkg::div_t div_data;

    logic              done_reg;
    rgbhsv_pkg::hue_t  hue_reg;
    rgbhsv_pkg::hue_t  hue_next;
    rgbhsv_pkg::chan_t sat_reg;
    rgbhsv_pkg::chan_t sat_next;
    rgbhsv_pkg::chan_t value_reg;

    // The pipeline advances every cycle, so a request is never refused
    assign busy   = 1'b0;
    assign accept = start && !busy;

    rgbhsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    rgbhsv_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // Drop the divider's quotients for grey pixels: its divisor was zero there
    always_comb
    begin
        hue_next = div_data.grey ? '0 : div_data.h_quo;
        sat_next = div_data.grey ? '0 : div_data.s_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    // Hold the result for the strobe cycle
    always_ff @(posedge clk)
    begin
        hue_reg   <= hue_next;
        sat_reg   <= sat_next;
        value_reg <= div_data.value;
    end

    assign done       = done_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign value      = value_reg;

`ifndef NO_ASSERTIONS
    // Every request yields exactly one strobe, and every strobe has a matching request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, rgbhsv_pkg::PIPE_LATENCY))
        else $error("result strobe without matching request");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(rgbhsv_pkg::PIPE_LATENCY) done)
        else $error("request did not produce a result");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hue <= rgbhsv_pkg::hue_t'(rgbhsv_pkg::HUE_MAX))
        else $error("hue out of range");

    // Zero saturation only happens for grey pixels, which carry zero hue
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturation == '0 |-> hue == '0)
        else $error("nonzero hue with zero saturation");
`endif

endmodule
